// ----- src/calendar_date_stepper_macros.svh -----
// assertion macros for the calendar date stepper
`ifndef CALENDAR_DATE_STEPPER_MACROS_SVH
`define CALENDAR_DATE_STEPPER_MACROS_SVH

// same-cycle implication, checked outside reset
`define CDS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define CDS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/cds_pkg.sv -----
// types, constants and calendar helper functions for the calendar date stepper
package cds_pkg;

	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;
	localparam int WDAY_W  = 3;
	localparam int CNT_W   = 16;
	localparam int YR400_W = 9;

	localparam int MAX_YEAR_DEF = 9999;

	// reset date, 1 jan 2026 (a thursday)
	localparam logic [DAY_W-1:0]   RESET_DAY   = 5'd1;
	localparam logic [MONTH_W-1:0] RESET_MONTH = 4'd1;
	localparam logic [YEAR_W-1:0]  RESET_YEAR  = 14'd2026;
	localparam logic [YR400_W-1:0] RESET_YR400 = YR400_W'(2026 % 400);
	localparam logic [WDAY_W-1:0]  RESET_WDAY  = 3'd4;

	// reciprocals for division by constants, and multiplier constants, on the shared multiplier
	localparam logic [14:0] RECIP100 = 15'd5243;   // x/100 = (x*5243) >> 19, x < 4096
	localparam logic [14:0] RECIP7   = 15'd18725;  // x/7 = (x*18725) >> 17, x < 32768
	localparam logic [14:0] MUL400   = 15'd400;
	localparam logic [14:0] MUL7     = 15'd7;

	typedef enum logic [1:0] {
		CMD_SET  = 2'd0,
		CMD_ADD  = 2'd1,
		CMD_SNAP = 2'd2,
		CMD_READ = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_DATE = 2'd1,
		ERR_WDAY = 2'd2,
		ERR_YEAR = 2'd3
	} err_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_Q400,
		ST_REM,
		ST_SUM,
		ST_MOD7,
		ST_WDAY,
		ST_STEP,
		ST_COMMIT,
		ST_DONE
	} state_t;

	// leap year from the year modulo 400
	function automatic logic is_leap(input logic [YR400_W-1:0] r);
		return (r == '0) ||
			((r[1:0] == 2'b00) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300));
	endfunction

	// month length, zero for a month outside 1..12
	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] d;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
			4'd2: d = leap ? 5'd29 : 5'd28;
			default: d = 5'd0;
		endcase
		return d;
	endfunction

	// month offset of the weekday formula
	function automatic logic [2:0] sak_off(input logic [MONTH_W-1:0] m);
		logic [2:0] o;
		case (m)
			4'd1:  o = 3'd0;
			4'd2:  o = 3'd3;
			4'd3:  o = 3'd2;
			4'd4:  o = 3'd5;
			4'd5:  o = 3'd0;
			4'd6:  o = 3'd3;
			4'd7:  o = 3'd5;
			4'd8:  o = 3'd1;
			4'd9:  o = 3'd4;
			4'd10: o = 3'd6;
			4'd11: o = 3'd2;
			4'd12: o = 3'd4;
			default: o = 3'd0;
		endcase
		return o;
	endfunction

endpackage

// ----- src/calendar_date_stepper.sv -----
// calendar date stepper: stored gregorian date with set, add, snap and read
// a read or a bad weekday goes straight to done; a set runs the weekday sum (a rejected date ends
// at the check), add or snap step |n| days, one per cycle (|n| up to 32768)
// one word at a time, a new word may start in the done cycle
// no output stall
// reset: asynchronous, date 1.1.2026 (thursday), idle, no result pending
module calendar_date_stepper import cds_pkg::*; #(
	parameter int MAX_YEAR = MAX_YEAR_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                command,
	input  logic [DAY_W-1:0]          new_day,
	input  logic [MONTH_W-1:0]        new_month,
	input  logic [YEAR_W-1:0]         new_year,
	input  logic signed [CNT_W-1:0]   day_count,
	input  logic [WDAY_W-1:0]         target_weekday,
	output logic                      done,
	output logic [DAY_W-1:0]          cur_day,
	output logic [MONTH_W-1:0]        cur_month,
	output logic [YEAR_W-1:0]         cur_year,
	output logic [WDAY_W-1:0]         day_of_week,
	output logic [1:0]                error_code
);

	`include "calendar_date_stepper_macros.svh"

	localparam logic [YEAR_W:0] MaxY = MAX_YEAR[YEAR_W:0];

	state_t state_q, state_d;
	logic   done_q, done_d;
	err_t   err_q;

	// stored date
	logic [DAY_W-1:0]   day_q;
	logic [MONTH_W-1:0] month_q;
	logic [YEAR_W-1:0]  year_q;
	logic [YR400_W-1:0] yr400_q;
	logic [WDAY_W-1:0]  wday_q;

	// working date and step control
	logic [DAY_W-1:0]   wd_q;
	logic [MONTH_W-1:0] wm_q;
	logic [YEAR_W-1:0]  wy_q;
	logic [YR400_W-1:0] wr_q;
	logic [WDAY_W-1:0]  ww_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               fwd_q;

	// weekday computation intermediates
	logic [5:0]         q400_q;
	logic [YR400_W-1:0] rem_q;
	logic [14:0]        sum_q;
	logic [11:0]        q7_q;

	logic accept;
	assign accept = (state_q == ST_IDLE) && start;

	// snap distance in both directions
	logic [3:0]        t_minus;
	logic [2:0]        snap_fwd, snap_bwd;
	logic              snap_go_fwd;
	logic [CNT_W-1:0]  snap_cnt;
	always_comb begin
		t_minus     = {1'b0, target_weekday} + 4'd7 - {1'b0, wday_q};
		snap_fwd    = (t_minus >= 4'd7) ? 3'(t_minus - 4'd7) : t_minus[2:0];
		snap_bwd    = (snap_fwd == 3'd0) ? 3'd0 : 3'(3'd7 - snap_fwd);
		snap_go_fwd = (snap_fwd <= snap_bwd);
		snap_cnt    = snap_go_fwd ? CNT_W'(snap_fwd) : CNT_W'(snap_bwd);
	end

	// magnitude of the day count
	logic [CNT_W-1:0] add_mag;
	assign add_mag = day_count[CNT_W-1] ? CNT_W'(-day_count) : CNT_W'(day_count);

	// shared multiplier
	logic [14:0] mul_a, mul_b;
	logic [29:0] mul_p;
	logic [YEAR_W-1:0] y_eff;
	always_comb begin
		y_eff = (wm_q < 4'd3) ? ((wy_q == '0) ? '0 : YEAR_W'(wy_q - 1'b1)) : wy_q;
		case (state_q)
			ST_Q400: begin
				mul_a = {3'b0, y_eff[YEAR_W-1:2]};
				mul_b = RECIP100;
			end
			ST_REM: begin
				mul_a = {9'b0, q400_q};
				mul_b = MUL400;
			end
			ST_MOD7: begin
				mul_a = sum_q;
				mul_b = RECIP7;
			end
			ST_WDAY: begin
				mul_a = {3'b0, q7_q};
				mul_b = MUL7;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// set check and weekday sum
	logic [YEAR_W-1:0]  rem_full;
	logic [YR400_W-1:0] ny_r;
	logic [1:0]         c100;
	logic [15:0]        sum_w;
	logic               set_ok;
	logic [2:0]         w7;
	always_comb begin
		rem_full = YEAR_W'(y_eff - mul_p[YEAR_W-1:0]);
		if (wm_q < 4'd3) begin
			ny_r = (rem_q == 9'd399) ? '0 : YR400_W'(rem_q + 1'b1);
		end else begin
			ny_r = rem_q;
		end
		if (rem_q >= 9'd300) begin
			c100 = 2'd3;
		end else if (rem_q >= 9'd200) begin
			c100 = 2'd2;
		end else if (rem_q >= 9'd100) begin
			c100 = 2'd1;
		end else begin
			c100 = 2'd0;
		end
		set_ok = (wy_q != '0) && ({1'b0, wy_q} <= MaxY) &&
			(wm_q >= 4'd1) && (wm_q <= 4'd12) && (wd_q != '0) &&
			(wd_q <= month_days(wm_q, is_leap(ny_r)));
		sum_w = {2'b0, y_eff} + {4'b0, y_eff[YEAR_W-1:2]}
			- {8'b0, q400_q, 2'b00} - {14'b0, c100} + {10'b0, q400_q}
			+ {13'b0, sak_off(wm_q)} + {11'b0, wd_q};
		w7 = 3'(sum_q - mul_p[14:0]);
	end

	// one day step of the working date
	logic [DAY_W-1:0]   mdays_cur, mdays_prev;
	logic [MONTH_W-1:0] m_prev;
	logic [YEAR_W:0]    wy_inc;
	logic               step_fail;
	logic [DAY_W-1:0]   sd;
	logic [MONTH_W-1:0] sm;
	logic [YEAR_W-1:0]  sy;
	logic [YR400_W-1:0] sr;
	logic [WDAY_W-1:0]  sw;
	always_comb begin
		mdays_cur  = month_days(wm_q, is_leap(wr_q));
		m_prev     = MONTH_W'(wm_q - 1'b1);
		mdays_prev = month_days(m_prev, is_leap(wr_q));
		wy_inc     = {1'b0, wy_q} + 1'b1;
		sd = wd_q;
		sm = wm_q;
		sy = wy_q;
		sr = wr_q;
		step_fail = 1'b0;
		if (fwd_q) begin
			sw = (ww_q == 3'd7) ? 3'd1 : 3'(ww_q + 1'b1);
			if (wd_q >= mdays_cur) begin
				sd = 5'd1;
				if (wm_q >= 4'd12) begin
					sm = 4'd1;
					sy = wy_inc[YEAR_W-1:0];
					sr = (wr_q == 9'd399) ? '0 : YR400_W'(wr_q + 1'b1);
					step_fail = (wy_inc > MaxY);
				end else begin
					sm = MONTH_W'(wm_q + 1'b1);
				end
			end else begin
				sd = DAY_W'(wd_q + 1'b1);
			end
		end else begin
			sw = (ww_q == 3'd1) ? 3'd7 : 3'(ww_q - 1'b1);
			if (wd_q <= 5'd1) begin
				if (wm_q <= 4'd1) begin
					sm = 4'd12;
					sy = YEAR_W'(wy_q - 1'b1);
					sr = (wr_q == '0) ? 9'd399 : YR400_W'(wr_q - 1'b1);
					sd = 5'd31;
					step_fail = (wy_q <= 14'd1);
				end else begin
					sm = m_prev;
					sd = mdays_prev;
				end
			end else begin
				sd = DAY_W'(wd_q - 1'b1);
			end
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	// next state and result strobe
	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (cmd_t'(command))
						CMD_SET: state_d = ST_Q400;
						CMD_ADD: state_d = (day_count == '0) ? ST_COMMIT : ST_STEP;
						CMD_SNAP: begin
							if (target_weekday == '0) begin
								state_d = ST_DONE;
							end else begin
								state_d = (snap_cnt == '0) ? ST_COMMIT : ST_STEP;
							end
						end
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_Q400: state_d = ST_REM;
			ST_REM:  state_d = ST_SUM;
			ST_SUM: begin
				if (set_ok) begin
					state_d = ST_MOD7;
				end else begin
					state_d = ST_IDLE;
					done_d  = 1'b1;
				end
			end
			ST_MOD7: state_d = ST_WDAY;
			ST_WDAY: state_d = ST_COMMIT;
			ST_STEP: begin
				if (step_fail) begin
					state_d = ST_IDLE;
					done_d  = 1'b1;
				end else if (cnt_q == CNT_W'(1)) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT, ST_DONE: begin
				state_d = ST_IDLE;
				done_d  = 1'b1;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// stored date and error code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_q   <= RESET_DAY;
			month_q <= RESET_MONTH;
			year_q  <= RESET_YEAR;
			yr400_q <= RESET_YR400;
			wday_q  <= RESET_WDAY;
			err_q   <= ERR_NONE;
		end else begin
			if (accept) begin
				err_q <= ((cmd_t'(command) == CMD_SNAP) && (target_weekday == '0)) ?
					ERR_WDAY : ERR_NONE;
			end
			if ((state_q == ST_SUM) && !set_ok) begin
				err_q <= ERR_DATE;
			end
			if ((state_q == ST_STEP) && step_fail) begin
				err_q <= ERR_YEAR;
			end
			if (state_q == ST_COMMIT) begin
				day_q   <= wd_q;
				month_q <= wm_q;
				year_q  <= wy_q;
				yr400_q <= wr_q;
				wday_q  <= ww_q;
			end
		end
	end

	// working date datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (cmd_t'(command) == CMD_SET) begin
						wd_q <= new_day;
						wm_q <= new_month;
						wy_q <= new_year;
					end else begin
						wd_q <= day_q;
						wm_q <= month_q;
						wy_q <= year_q;
						wr_q <= yr400_q;
						ww_q <= wday_q;
					end
					if (cmd_t'(command) == CMD_SNAP) begin
						cnt_q <= snap_cnt;
						fwd_q <= snap_go_fwd;
					end else begin
						cnt_q <= add_mag;
						fwd_q <= !day_count[CNT_W-1];
					end
				end
			end
			ST_Q400: q400_q <= mul_p[24:19];
			ST_REM:  rem_q  <= rem_full[YR400_W-1:0];
			ST_SUM: begin
				wr_q  <= ny_r;
				sum_q <= sum_w[14:0];
			end
			ST_MOD7: q7_q <= mul_p[28:17];
			ST_WDAY: ww_q <= (w7 == 3'd0) ? 3'd7 : w7;
			ST_STEP: begin
				if (!step_fail) begin
					wd_q  <= sd;
					wm_q  <= sm;
					wy_q  <= sy;
					wr_q  <= sr;
					ww_q  <= sw;
					cnt_q <= CNT_W'(cnt_q - 1'b1);
				end
			end
			default: begin
			end
		endcase
	end

	// result ports
	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign cur_day     = day_q;
	assign cur_month   = month_q;
	assign cur_year    = year_q;
	assign day_of_week = wday_q;
	assign error_code  = err_q;

	// checks
	`CDS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
	`CDS_ASSERT_IMPL(a_done_idle, done, !busy || $past(state_q == ST_IDLE), "done while working")
	`CDS_ASSERT_NEXT(a_date_hold, state_q != ST_COMMIT, $stable(day_q) && $stable(month_q) && $stable(year_q), "stored date changed outside commit")
	`CDS_ASSERT_NEXT(a_commit_done, state_q == ST_COMMIT, done && (err_q == ERR_NONE), "commit without clean result")
	`CDS_ASSERT_IMPL(a_date_legal, 1'b1, (day_q != '0) && (month_q >= 4'd1) && (month_q <= 4'd12) && (wday_q != '0), "stored date out of range")

endmodule
